// ===== rtl/rrps_pkg.sv =====
// Shared types, codes and constants of the round-robin process scheduler.
package rrps_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot LAST_SLOT = t_slot'(NUM_SLOTS - 1);

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_BLOCK = 3'd1;
    localparam logic [2:0] CMD_WAKE  = 3'd2;
    localparam logic [2:0] CMD_KILL  = 3'd3;
    localparam logic [2:0] CMD_EXIT  = 3'd4;
    localparam logic [2:0] CMD_ALLOC = 3'd5;

    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [1:0] STS_DONE     = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_NOEFFECT = 2'd2;

    localparam logic [1:0] NXT_DONE  = 2'd0;
    localparam logic [1:0] NXT_SCAN  = 2'd1;
    localparam logic [1:0] NXT_ALLOC = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] target_slot;
    } t_in;

    typedef struct packed {
        logic [2:0] running_slot;
        logic       switched;
        logic [2:0] new_slot;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        logic load_in;
        logic look;
        logic scan_step;
        logic alloc_step;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic [1:0] look_next;
        logic       hit;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/rrps_ctrl.sv =====
// Sequencing state machine of the round-robin process scheduler.
module rrps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rrps_pkg::t_sts i_sts,
    output rrps_pkg::t_ctl o_ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_ctl            = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_ctl.look = 1'b1;
                case (i_sts.look_next)
                    rrps_pkg::NXT_SCAN:  n_state = S_SCAN;
                    rrps_pkg::NXT_ALLOC: n_state = S_ALLOC;
                    default:             n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_ALLOC: begin
                o_ctl.alloc_step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/rrps_dp.sv =====
// Slot state file, scan index and result register of the round-robin process scheduler.
module rrps_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrps_pkg::t_in  i_in_data,
    input  rrps_pkg::t_ctl i_ctl,
    output rrps_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rrps_pkg::t_out o_out_data
);

    logic [1:0]      r_slots [rrps_pkg::NUM_SLOTS];
    logic [2:0]      r_cmd;
    logic [2:0]      r_tgt;
    rrps_pkg::t_slot r_cur;
    rrps_pkg::t_slot r_idx;
    rrps_pkg::t_slot r_cnt;
    logic            r_sw;
    logic [2:0]      r_new;
    logic [1:0]      r_status;
    logic            r_out_valid;
    rrps_pkg::t_out  r_out;

    rrps_pkg::t_slot n_cur;
    rrps_pkg::t_slot n_idx;
    rrps_pkg::t_slot n_cnt;
    logic            n_sw;
    logic [2:0]      n_new;
    logic [1:0]      n_status;

    rrps_pkg::t_slot tgt_idx;
    logic            tgt_ok;
    rrps_pkg::t_slot rd_addr;
    logic [1:0]      rd;
    logic            wr_en;
    rrps_pkg::t_slot wr_addr;
    logic [1:0]      wr_data;

    function automatic rrps_pkg::t_slot slot_inc(input rrps_pkg::t_slot x);
        return (x == rrps_pkg::LAST_SLOT) ? '0 : x + rrps_pkg::t_slot'(1);
    endfunction

    assign tgt_idx = rrps_pkg::t_slot'(r_tgt);
    assign tgt_ok  = (int'(r_tgt) < rrps_pkg::NUM_SLOTS);

    always_comb begin
        if (i_ctl.look) begin
            rd_addr = ((r_cmd == rrps_pkg::CMD_WAKE) || (r_cmd == rrps_pkg::CMD_KILL)) ?
                      tgt_idx : r_cur;
        end else begin
            rd_addr = r_idx;
        end
    end

    assign rd = r_slots[rd_addr];

    always_comb begin
        n_cur           = r_cur;
        n_idx           = r_idx;
        n_cnt           = r_cnt;
        n_sw            = r_sw;
        n_new           = r_new;
        n_status        = r_status;
        wr_en           = 1'b0;
        wr_addr         = r_idx;
        wr_data         = rrps_pkg::ST_UNUSED;
        o_sts.look_next = rrps_pkg::NXT_DONE;
        o_sts.hit       = 1'b0;
        o_sts.out_free  = !r_out_valid || !i_out_stall;

        if (i_ctl.load_in) begin
            n_sw     = 1'b0;
            n_new    = 3'd0;
            n_status = rrps_pkg::STS_DONE;
        end else if (i_ctl.look) begin
            case (r_cmd)
                rrps_pkg::CMD_TICK, rrps_pkg::CMD_BLOCK: begin
                    wr_en           = (rd != rrps_pkg::ST_UNUSED);
                    wr_addr         = r_cur;
                    wr_data         = (r_cmd == rrps_pkg::CMD_TICK) ?
                                      rrps_pkg::ST_READY : rrps_pkg::ST_BLOCKED;
                    n_idx           = slot_inc(r_cur);
                    n_cnt           = '0;
                    o_sts.look_next = rrps_pkg::NXT_SCAN;
                end
                rrps_pkg::CMD_WAKE: begin
                    if (tgt_ok && (rd == rrps_pkg::ST_BLOCKED)) begin
                        wr_en   = 1'b1;
                        wr_addr = tgt_idx;
                        wr_data = rrps_pkg::ST_READY;
                    end else begin
                        n_status = rrps_pkg::STS_NOEFFECT;
                    end
                end
                rrps_pkg::CMD_KILL: begin
                    if (!tgt_ok || (rd == rrps_pkg::ST_UNUSED)) begin
                        n_status = rrps_pkg::STS_NOEFFECT;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = tgt_idx;
                        wr_data = rrps_pkg::ST_UNUSED;
                        if (tgt_idx == r_cur) begin
                            n_idx           = slot_inc(r_cur);
                            n_cnt           = '0;
                            o_sts.look_next = rrps_pkg::NXT_SCAN;
                        end
                    end
                end
                rrps_pkg::CMD_EXIT: begin
                    wr_en           = 1'b1;
                    wr_addr         = r_cur;
                    wr_data         = rrps_pkg::ST_UNUSED;
                    n_idx           = slot_inc(r_cur);
                    n_cnt           = '0;
                    o_sts.look_next = rrps_pkg::NXT_SCAN;
                end
                rrps_pkg::CMD_ALLOC: begin
                    n_idx           = rrps_pkg::t_slot'(1);
                    o_sts.look_next = rrps_pkg::NXT_ALLOC;
                end
                default: begin
                    n_status = rrps_pkg::STS_NOEFFECT;
                end
            endcase
        end else if (i_ctl.scan_step) begin
            if ((rd == rrps_pkg::ST_READY) || (r_cnt == rrps_pkg::LAST_SLOT)) begin
                o_sts.hit = 1'b1;
                wr_en     = 1'b1;
                wr_addr   = r_idx;
                wr_data   = rrps_pkg::ST_RUNNING;
                n_cur     = r_idx;
                n_sw      = 1'b1;
            end else begin
                n_idx = slot_inc(r_idx);
                n_cnt = r_cnt + rrps_pkg::t_slot'(1);
            end
        end else if (i_ctl.alloc_step) begin
            if (rd == rrps_pkg::ST_UNUSED) begin
                o_sts.hit = 1'b1;
                wr_en     = 1'b1;
                wr_addr   = r_idx;
                wr_data   = rrps_pkg::ST_READY;
                n_new     = 3'(r_idx);
            end else if (r_idx == rrps_pkg::LAST_SLOT) begin
                o_sts.hit = 1'b1;
                n_status  = rrps_pkg::STS_FULL;
            end else begin
                n_idx = slot_inc(r_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++) begin
                r_slots[i] <= (i == 0) ? rrps_pkg::ST_RUNNING : rrps_pkg::ST_UNUSED;
            end
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_slots[wr_addr] <= wr_data;
            end
            r_cur <= n_cur;
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= i_in_data.cmd;
            r_tgt <= i_in_data.target_slot;
        end
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_sw     <= n_sw;
        r_new    <= n_new;
        r_status <= n_status;
        if (i_ctl.emit) begin
            r_out.running_slot <= 3'(r_cur);
            r_out.switched     <= r_sw;
            r_out.new_slot     <= r_new;
            r_out.status       <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/round_robin_process_scheduler.sv =====
// Top level of the round-robin process scheduler: controller, datapath and checks.
//
//   channel | direction | handshake                | payload
//   input   | in        | i_in_valid / o_in_stall  | i_in_data  (cmd, target_slot)
//   output  | out       | o_out_valid / i_out_stall| o_out_data (running_slot, switched,
//           |           |                          |             new_slot, status)
//
// One command is handled at a time. Wake, undefined commands and kills of a slot
// that is not running finish without a scan; tick, block, exit and a kill of the
// running slot scan up to NUM_SLOTS slot states, and allocate scans up to
// NUM_SLOTS - 1, reading one slot state per cycle.
// Reset is synchronous; after it slot 0 runs and all other slots are unused.
// A finished result waits in the output register while a stalled output holds it,
// and the next command is taken in the meantime.
module round_robin_process_scheduler (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rrps_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rrps_pkg::t_out o_out_data
);

    rrps_pkg::t_ctl ctl;
    rrps_pkg::t_sts sts;

    rrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    rrps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input taken while a command was still in work.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("Result carries an unknown status.");

    a_switch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.switched) |->
        (o_out_data.status == rrps_pkg::STS_DONE && o_out_data.new_slot == 3'd0))
        else $error("Switch reported together with a failure or an allocation.");

    a_alloc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.new_slot != 3'd0) |->
        (o_out_data.status == rrps_pkg::STS_DONE))
        else $error("Allocated slot reported with a failure status.");

endmodule

// ===== sim/rrps_result_checker.sv =====
// Result checker for the round-robin process scheduler: slot-state predictor and scoreboard.
`timescale 1ns / 100ps

module rrps_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  rrps_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  rrps_pkg::t_out i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked,
    output int             o_switches,
    output int             o_full,
    output int             o_noeffect
);

    logic [1:0]      slot_state [rrps_pkg::NUM_SLOTS];
    rrps_pkg::t_slot running;
    rrps_pkg::t_out  expected_results [$];

    function automatic rrps_pkg::t_slot next_ready();
        rrps_pkg::t_slot cand;
        for (int i = 1; i <= rrps_pkg::NUM_SLOTS; i++) begin
            cand = rrps_pkg::t_slot'((int'(running) + i) % rrps_pkg::NUM_SLOTS);
            if (slot_state[cand] == rrps_pkg::ST_READY) begin
                return cand;
            end
        end
        return running;
    endfunction

    function automatic void switch_context();
        running = next_ready();
        slot_state[running] = rrps_pkg::ST_RUNNING;
    endfunction

    function automatic rrps_pkg::t_out schedule_command(input rrps_pkg::t_in item);
        rrps_pkg::t_out res;
        res.switched = 1'b0;
        res.new_slot = '0;
        res.status   = rrps_pkg::STS_DONE;
        case (item.cmd)
            rrps_pkg::CMD_TICK, rrps_pkg::CMD_BLOCK: begin
                if (slot_state[running] != rrps_pkg::ST_UNUSED) begin
                    slot_state[running] = (item.cmd == rrps_pkg::CMD_TICK) ?
                                          rrps_pkg::ST_READY : rrps_pkg::ST_BLOCKED;
                end
                switch_context();
                res.switched = 1'b1;
            end
            rrps_pkg::CMD_WAKE: begin
                if (int'(item.target_slot) < rrps_pkg::NUM_SLOTS
                        && slot_state[item.target_slot] == rrps_pkg::ST_BLOCKED) begin
                    slot_state[item.target_slot] = rrps_pkg::ST_READY;
                end else begin
                    res.status = rrps_pkg::STS_NOEFFECT;
                end
            end
            rrps_pkg::CMD_KILL: begin
                if (int'(item.target_slot) >= rrps_pkg::NUM_SLOTS
                        || slot_state[item.target_slot] == rrps_pkg::ST_UNUSED) begin
                    res.status = rrps_pkg::STS_NOEFFECT;
                end else begin
                    slot_state[item.target_slot] = rrps_pkg::ST_UNUSED;
                    if (int'(item.target_slot) == int'(running)) begin
                        switch_context();
                        res.switched = 1'b1;
                    end
                end
            end
            rrps_pkg::CMD_EXIT: begin
                slot_state[running] = rrps_pkg::ST_UNUSED;
                switch_context();
                res.switched = 1'b1;
            end
            rrps_pkg::CMD_ALLOC: begin
                res.status = rrps_pkg::STS_FULL;
                for (int i = 1; i < rrps_pkg::NUM_SLOTS; i++) begin
                    if (res.status == rrps_pkg::STS_FULL
                            && slot_state[i] == rrps_pkg::ST_UNUSED) begin
                        slot_state[i] = rrps_pkg::ST_READY;
                        res.new_slot  = 3'(i);
                        res.status    = rrps_pkg::STS_DONE;
                    end
                end
            end
            default: begin
                res.status = rrps_pkg::STS_NOEFFECT;
            end
        endcase
        res.running_slot = 3'(running);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [2:0] exp_val,
                               input logic [2:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            o_errors++;
        end
    endtask

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        o_checked  = 0;
        o_switches = 0;
        o_full     = 0;
        o_noeffect = 0;
    end

    always @(posedge i_clk) begin
        rrps_pkg::t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++) begin
                slot_state[i] = rrps_pkg::ST_UNUSED;
            end
            slot_state[0] = rrps_pkg::ST_RUNNING;
            running = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result %p arrived with nothing expected", $time,
                             i_out_data);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("running_slot", want.running_slot, i_out_data.running_slot);
                    check_field("switched", 3'(want.switched), 3'(i_out_data.switched));
                    check_field("new_slot", want.new_slot, i_out_data.new_slot);
                    check_field("status", 3'(want.status), 3'(i_out_data.status));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = schedule_command(i_in_data);
                expected_results.push_back(want);
                if (want.switched) begin
                    o_switches++;
                end
                if (want.status == rrps_pkg::STS_FULL) begin
                    o_full++;
                end
                if (want.status == rrps_pkg::STS_NOEFFECT) begin
                    o_noeffect++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/tb_round_robin_process_scheduler.sv =====
// Testbench top for the round-robin process scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_round_robin_process_scheduler;

    localparam int CYCLE_LIMIT     = 500_000;
    localparam int RANDOM_COMMANDS = 2000;

    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;
    typedef enum {MIX_FILL, MIX_CHURN, MIX_TEARDOWN, MIX_NOISE} t_mix;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    rrps_pkg::t_in  in_data;
    logic           out_valid;
    logic           out_stall;
    rrps_pkg::t_out out_data;

    int errors;
    int pending;
    int checked;
    int switches;
    int full_count;
    int noeffect_count;
    int cycle_count;

    t_stall_mode stall_mode;
    int          mode_left;

    round_robin_process_scheduler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rrps_result_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_switches  (switches),
        .o_full      (full_count),
        .o_noeffect  (noeffect_count)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, cycle_count, pending);
            $display("[round_robin_process_scheduler] ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
            default:     out_stall <= ((mode_left % 16) < 10);
        endcase
    end

    task automatic send_command(input logic [2:0] op, input logic [2:0] slot);
        in_valid <= 1'b1;
        in_data  <= rrps_pkg::t_in'{cmd: op, target_slot: slot};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic hold_sender(input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [2:0] pick_command(input t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 50) return rrps_pkg::CMD_ALLOC;
                if (roll < 75) return rrps_pkg::CMD_TICK;
                if (roll < 90) return rrps_pkg::CMD_WAKE;
                return rrps_pkg::CMD_BLOCK;
            end
            MIX_CHURN: begin
                if (roll < 35) return rrps_pkg::CMD_TICK;
                if (roll < 60) return rrps_pkg::CMD_BLOCK;
                if (roll < 85) return rrps_pkg::CMD_WAKE;
                if (roll < 95) return rrps_pkg::CMD_ALLOC;
                return rrps_pkg::CMD_KILL;
            end
            MIX_TEARDOWN: begin
                if (roll < 40) return rrps_pkg::CMD_KILL;
                if (roll < 65) return rrps_pkg::CMD_EXIT;
                if (roll < 85) return rrps_pkg::CMD_TICK;
                if (roll < 95) return rrps_pkg::CMD_BLOCK;
                return rrps_pkg::CMD_ALLOC;
            end
            default: begin
                return 3'($urandom_range(0, 7));
            end
        endcase
    endfunction

    initial begin
        int   sent;
        int   burst;
        int   mix_left;
        int   roll;
        t_mix mix;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        mix        = MIX_FILL;
        mix_left   = 0;
        sent       = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_command(rrps_pkg::CMD_TICK, 3'd0);
        send_command(rrps_pkg::CMD_BLOCK, 3'd7);
        send_command(rrps_pkg::CMD_WAKE, 3'd0);
        send_command(rrps_pkg::CMD_KILL, 3'd5);
        send_command(rrps_pkg::CMD_EXIT, 3'd2);
        send_command(rrps_pkg::CMD_KILL, 3'd0);
        repeat (7) send_command(rrps_pkg::CMD_ALLOC, 3'd0);
        send_command(rrps_pkg::CMD_ALLOC, 3'd7);
        send_command(rrps_pkg::CMD_TICK, 3'd4);
        send_command(rrps_pkg::CMD_BLOCK, 3'd1);
        send_command(rrps_pkg::CMD_WAKE, 3'd1);
        send_command(rrps_pkg::CMD_WAKE, 3'd3);
        send_command(rrps_pkg::CMD_KILL, 3'd4);
        send_command(rrps_pkg::CMD_KILL, 3'd2);
        send_command(rrps_pkg::CMD_EXIT, 3'd6);
        send_command(CMD_UNDEF_LO, 3'd0);
        send_command(CMD_UNDEF_HI, 3'd7);
        send_command(rrps_pkg::CMD_ALLOC, 3'd5);
        send_command(rrps_pkg::CMD_TICK, 3'd2);
        drain_results();

        while (sent < RANDOM_COMMANDS) begin
            if (mix_left <= 0) begin
                roll = $urandom_range(0, 99);
                mix = (roll < 30) ? MIX_FILL : (roll < 65) ? MIX_CHURN :
                      (roll < 85) ? MIX_TEARDOWN : MIX_NOISE;
                mix_left = $urandom_range(20, 80);
            end
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++) begin
                send_command(pick_command(mix), 3'($urandom_range(0, 7)));
                sent++;
                mix_left--;
            end
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                hold_sender($urandom_range(1, 8));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (2 * rrps_pkg::NUM_SLOTS + 8) @(posedge clk);

        $display("Checked %0d scheduler results: %0d context switches, %0d allocations refused,",
                 checked, switches, full_count);
        $display("%0d commands without effect, %0d mismatches.", noeffect_count, errors);
        if (errors == 0 && pending == 0) begin
            $display("[round_robin_process_scheduler] OK");
        end else begin
            $display("[round_robin_process_scheduler] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rrps_pkg.sv
rtl/rrps_ctrl.sv
rtl/rrps_dp.sv
rtl/round_robin_process_scheduler.sv
sim/rrps_result_checker.sv
sim/tb_round_robin_process_scheduler.sv
